@@ rtl/core/sorted_set_insert_remove_macros.svh @@
// Assertion macros shared by the sorted set RTL.
`ifndef SORTED_SET_INSERT_REMOVE_MACROS_SVH
`define SORTED_SET_INSERT_REMOVE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSIR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ssir_pkg.sv @@
// Shared types, codes and widths for the sorted set store.
package ssir_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam int ID_W          = 31;
   localparam int ENTRY_W       = 2 * ID_W;
   localparam int OPCODE_W      = 2;
   localparam int READ_IDX_W    = 6;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [ID_W-1:0]       key_x;
      logic [ID_W-1:0]       key_y;
      logic [READ_IDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic [ID_W-1:0]          entry_x;
      logic [ID_W-1:0]          entry_y;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                scan;
      logic                shift_init;
      logic                shift;
      logic                place;
      logic                inc;
      logic                dec;
      logic                rd_issue;
      logic                respond;
      logic [STATUS_W-1:0] status;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                scan_done;
      logic                shift_done;
      logic                found;
      logic                full;
      logic                idx_ok;
   } dp_stat_type;

endpackage

@@ rtl/core/ssir_ctrl.sv @@
// Request sequencer for the sorted set store.
module ssir_ctrl
   import ssir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [OPCODE_W-1:0] req_opcode,
   output logic                busy,
   output ctrl_cmd_type        cmd,
   input  dp_stat_type         stat
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_SHIFT = 5'b00100,
      S_RD    = 5'b01000,
      S_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_opcode == OP_INSERT || req_opcode == OP_REMOVE) begin
                  state_in = S_SCAN;
               end else if (req_opcode == OP_READ) begin
                  state_in = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               if (stat.opcode == OP_INSERT && stat.found) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_DUPLICATE;
                  state_in    = S_IDLE;
               end else if (stat.opcode == OP_INSERT && stat.full) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_FULL;
                  state_in    = S_IDLE;
               end else if (stat.opcode == OP_REMOVE && !stat.found) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_NOT_FOUND;
                  state_in    = S_IDLE;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_DONE;
               if (stat.opcode == OP_INSERT) begin
                  cmd.place = 1'b1;
                  cmd.inc   = 1'b1;
               end else begin
                  cmd.dec = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            cmd.status  = (stat.opcode == OP_READ && !stat.idx_ok) ? ST_RANGE : ST_DONE;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/ssir_datapath.sv @@
// Entry memory, scan and shift pointers and response register of the sorted set.
`include "sorted_set_insert_remove_macros.svh"

module ssir_datapath
   import ssir_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  req_type      req_data,
   input  logic         csr_valid,
   input  logic         csr_pair_mode,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > READ_IDX_W) ? CW : READ_IDX_W;

   logic [ENTRY_W-1:0] entry_mem_ff [CAPACITY];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic                  pair_mode_ff;
   logic                  pair_mode_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [OPCODE_W-1:0]   op_ff, op_in;
   logic [ID_W-1:0]       key_x_ff, key_x_in;
   logic [ID_W-1:0]       key_y_ff, key_y_in;
   logic [READ_IDX_W-1:0] ridx_ff, ridx_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         tgt_ff, tgt_in;
   logic                  scan_pend_ff, scan_pend_in;
   logic                  shift_pend_ff, shift_pend_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         fpos_ff, fpos_in;
   logic                  gt_ff, gt_in;
   logic [CW-1:0]         gpos_ff, gpos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ENTRY_W-1:0]    wr_data;

   logic [CW-1:0]         ptr_dec;
   logic [CW-1:0]         ptr_inc;
   logic [XW-1:0]         ridx_ext;
   logic                  idx_ok;
   logic [ID_W-1:0]       ent_x;
   logic [ID_W-1:0]       ent_y;
   logic                  ent_eq;
   logic                  ent_gt;
   logic                  shift_avail;

   assign ptr_dec  = ptr_ff - CW'(1);
   assign ptr_inc  = ptr_ff + CW'(1);
   assign ridx_ext = XW'(ridx_ff);
   assign idx_ok   = (ridx_ext < XW'(count_ff)) && (ridx_ext < XW'(CAPACITY));

   assign ent_x  = rd_data_ff[ENTRY_W-1:ID_W];
   assign ent_y  = rd_data_ff[ID_W-1:0];
   assign ent_eq = (ent_x == key_x_ff) && (!pair_mode_ff || (ent_y == key_y_ff));
   assign ent_gt = (ent_x > key_x_ff)
                   || (pair_mode_ff && (ent_x == key_x_ff) && (ent_y > key_y_ff));

   // Insert moves entries up from the top down to the insert slot; remove
   // moves entries down from just above the hole to the top.
   assign shift_avail = (op_ff == OP_INSERT) ? (ptr_ff > gpos_ff) : (ptr_ff < count_ff);

   assign pair_mode_in = csr_valid ? csr_pair_mode : pair_mode_ff;

   always_comb begin
      op_in         = op_ff;
      key_x_in      = key_x_ff;
      key_y_in      = key_y_ff;
      ridx_in       = ridx_ff;
      ptr_in        = ptr_ff;
      tgt_in        = tgt_ff;
      scan_pend_in  = 1'b0;
      shift_pend_in = 1'b0;
      found_in      = found_ff;
      fpos_in       = fpos_ff;
      gt_in         = gt_ff;
      gpos_in       = gpos_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = tgt_ff;
      wr_data       = rd_data_ff;

      if (cmd.load) begin
         op_in    = req_data.opcode;
         key_x_in = req_data.key_x;
         key_y_in = pair_mode_ff ? req_data.key_y : '0;
         ridx_in  = req_data.read_index;
         ptr_in   = '0;
         found_in = 1'b0;
         gt_in    = 1'b0;
         gpos_in  = count_ff;
      end

      if (cmd.scan && (ptr_ff < count_ff)) begin
         rd_en        = 1'b1;
         rd_addr      = ptr_ff[AW-1:0];
         tgt_in       = ptr_ff[AW-1:0];
         ptr_in       = ptr_inc;
         scan_pend_in = 1'b1;
      end

      if (scan_pend_ff) begin
         if (ent_eq && !found_ff) begin
            found_in = 1'b1;
            fpos_in  = tgt_ff;
         end
         if (ent_gt && !gt_ff) begin
            gt_in   = 1'b1;
            gpos_in = CW'(tgt_ff);
         end
      end

      if (cmd.shift_init) begin
         ptr_in = (op_ff == OP_INSERT) ? count_ff : (CW'(fpos_ff) + CW'(1));
      end

      if (cmd.shift && shift_avail) begin
         rd_en         = 1'b1;
         shift_pend_in = 1'b1;
         if (op_ff == OP_INSERT) begin
            rd_addr = ptr_dec[AW-1:0];
            tgt_in  = ptr_ff[AW-1:0];
            ptr_in  = ptr_dec;
         end else begin
            rd_addr = ptr_ff[AW-1:0];
            tgt_in  = ptr_dec[AW-1:0];
            ptr_in  = ptr_inc;
         end
      end

      if (shift_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = tgt_ff;
         wr_data = rd_data_ff;
      end

      if (cmd.rd_issue) begin
         rd_en   = 1'b1;
         rd_addr = ridx_ext[AW-1:0];
      end

      if (cmd.place) begin
         wr_en   = 1'b1;
         wr_addr = gpos_ff[AW-1:0];
         wr_data = {key_x_ff, key_y_ff};
      end

      if (cmd.inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.respond) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = cmd.status;
         rsp_data_in.entry_count = ENTRY_COUNT_W'(count_in);
         if (op_ff == OP_READ && idx_ok) begin
            rsp_data_in.entry_x = ent_x;
            rsp_data_in.entry_y = pair_mode_ff ? ent_y : '0;
         end else begin
            rsp_data_in.entry_x = '0;
            rsp_data_in.entry_y = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_mode_ff  <= 1'b1;
         count_ff      <= '0;
         scan_pend_ff  <= 1'b0;
         shift_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pair_mode_ff  <= pair_mode_in;
         count_ff      <= count_in;
         scan_pend_ff  <= scan_pend_in;
         shift_pend_ff <= shift_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_x_ff    <= key_x_in;
      key_y_ff    <= key_y_in;
      ridx_ff     <= ridx_in;
      ptr_ff      <= ptr_in;
      tgt_ff      <= tgt_in;
      found_ff    <= found_in;
      fpos_ff     <= fpos_in;
      gt_ff       <= gt_in;
      gpos_ff     <= gpos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.opcode     = op_ff;
   assign stat.scan_done  = !scan_pend_ff && (ptr_ff >= count_ff);
   assign stat.shift_done = !shift_pend_ff && !shift_avail;
   assign stat.found      = found_ff;
   assign stat.full       = (count_ff == CW'(CAPACITY));
   assign stat.idx_ok     = idx_ok;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SSIR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `SSIR_ASSERT_NEXT(a_reject_keeps_count, clock, reset, cmd.respond && (cmd.status != ST_DONE), count_ff == $past(count_ff), "rejected request changed count")
   `SSIR_ASSERT_SAME(a_place_no_move, clock, reset, cmd.place, !shift_pend_ff, "insert write collides with shift")

endmodule

@@ rtl/core/sorted_set_insert_remove.sv @@
// A read issues one memory read and then responds; an unused opcode goes straight to the respond step.
// Insert or remove scans the set, then shifts entries (one memory port pass each).
// The scan and the entry shift each go one entry per cycle through the single read port.
// The result strobe comes in the first cycle with busy low; a new start is taken there too.
// Synchronous active-high reset empties the set and selects pair mode; memory is not cleared.
// Results cannot be held off by the receiver: each is shown for exactly one cycle.
`include "sorted_set_insert_remove_macros.svh"

module sorted_set_insert_remove
   import ssir_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic    clock,
   input  logic    reset,

   // Request channel: a beat is taken when start is high and busy is low.
   input  logic    start,
   output logic    busy,
   input  req_type req_data,

   // Mode register write channel; always ready. Writes must only come while idle; the block does not enforce this.
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_pair_mode,

   // Response channel: one beat per request, valid for a single cycle.
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         csr_write;

   // The mode register lives in the datapath; it updates only on a full handshake.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // The controller walks each request through scan, shift, read and respond steps.
   // It sees the incoming opcode only to pick the first step; everything else
   // it learns from the datapath status.
   ssir_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_data.opcode),
      .busy       (busy),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds the sorted entries in a single-port-read memory,
   // compares each entry against the key as it streams out, and moves the
   // tail of the set one entry per cycle to open or close a slot.
   ssir_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data      (req_data),
      .csr_valid     (csr_write),
      .csr_pair_mode (csr_pair_mode),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   // A response beat is only produced as the controller returns to idle.
   `SSIR_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "response while busy")
   // An accepted request always makes the block busy on the next cycle.
   `SSIR_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted request did not start")
   // Each response beat lasts exactly one cycle.
   `SSIR_ASSERT_NEXT(a_rsp_one_cycle, clock, reset, rsp_valid, !rsp_valid, "strobe held too long")

endmodule
